/* src/assert_macros.svh */
// concurrent assertion helpers, clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

`endif

/* src/ldr_pkg.sv */
package ldr_pkg;

  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 1024;
  localparam int RADIAL_K3_DEF    = 0;

  localparam int ADDR_W      = 5;
  localparam int DIV_BITS    = 20;
  localparam int DIV_PER_STG = 2;
  localparam int DIV_STG     = DIV_BITS / DIV_PER_STG;
  localparam int NORM_LAT    = DIV_STG + 2;
  localparam int POLY_LAT    = 10;

  localparam logic [19:0] FOCAL_RST  = 20'd262144;
  localparam logic [19:0] CENTER_RST = 20'd131072;

  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
  } pix_t;

  typedef struct packed {
    logic [11:0] src_col;
    logic [11:0] src_row;
    logic        in_bounds;
  } src_t;

  typedef struct packed {
    logic        [19:0] focal_x;
    logic        [19:0] focal_y;
    logic        [19:0] center_x;
    logic        [19:0] center_y;
    logic signed [19:0] radial_k1;
    logic signed [19:0] radial_k2;
    logic signed [19:0] tangential_p1;
    logic signed [19:0] tangential_p2;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIAL_K1,
    REG_RADIAL_K2,
    REG_TANGENTIAL_P1,
    REG_TANGENTIAL_P2
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (a < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return a[31:0];
    end
  endfunction

  // q.16 product, floor rounding, saturated
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p >>> 16);
  endfunction

endpackage

/* src/lens_distortion_remap.sv */
// channel | valid     | stall     | word
// pix     | pix_valid | pix_stall | pix (out_col, out_row)
// src     | src_valid | src_stall | src (src_col, src_row, in_bounds)
// one word per cycle sustained while no src word is held; each word runs from pix to src
// through the normalize divider (2 quotient bits per stage) and then the polynomial
// rst clears the valid bits and loads the register defaults
// a held src word stalls the whole pipeline, pix_stall follows at once
module lens_distortion_remap #(
  parameter int IMAGE_WIDTH  = ldr_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = ldr_pkg::IMAGE_HEIGHT_DEF,
  parameter int RADIAL_K3    = ldr_pkg::RADIAL_K3_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  output logic                       pix_stall,
  input  ldr_pkg::pix_t              pix,
  output logic                       src_valid,
  input  logic                       src_stall,
  output ldr_pkg::src_t              src,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ldr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  `include "assert_macros.svh"

  localparam int LAT = ldr_pkg::NORM_LAT + ldr_pkg::POLY_LAT;

  ldr_pkg::cfg_t      cfg;
  logic               en;
  logic [LAT-1:0]     vld;
  logic signed [19:0] nx, ny;

  assign en        = !(vld[LAT-1] && src_stall);
  assign pix_stall = !en;
  assign src_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pix_valid};
    end
  end

  ldr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ldr_norm u_norm_x (
    .clk, .en, .pix(pix.out_col), .center(cfg.center_x), .focal(cfg.focal_x), .norm(nx)
  );

  ldr_norm u_norm_y (
    .clk, .en, .pix(pix.out_row), .center(cfg.center_y), .focal(cfg.focal_y), .norm(ny)
  );

  ldr_poly #(
    .IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT), .RADIAL_K3(RADIAL_K3)
  ) u_poly (
    .clk, .en, .x(nx), .y(ny), .cfg, .res(src)
  );

  `ASSERT_IMPLIES(a_oob_zero, clk, rst, src_valid && !src.in_bounds, src.src_col == '0 && src.src_row == '0, "out of bounds word carries nonzero coordinates")
  `ASSERT_IMPLIES(a_col_range, clk, rst, src_valid && src.in_bounds, 32'(src.src_col) < 32'(IMAGE_WIDTH), "source column beyond image width")
  `ASSERT_IMPLIES(a_row_range, clk, rst, src_valid && src.in_bounds, 32'(src.src_row) < 32'(IMAGE_HEIGHT), "source row beyond image height")
  `ASSERT_CLK(a_stall_link, clk, rst, (src_valid && src_stall) |=> pix_stall || !src_valid || !src_stall, "pipeline moved while output held")

endmodule

/* src/ldr_cfg.sv */
module ldr_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ldr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ldr_pkg::cfg_t             cfg
);

  ldr_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = ldr_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x       <= ldr_pkg::FOCAL_RST;
      cfg.focal_y       <= ldr_pkg::FOCAL_RST;
      cfg.center_x      <= ldr_pkg::CENTER_RST;
      cfg.center_y      <= ldr_pkg::CENTER_RST;
      cfg.radial_k1     <= '0;
      cfg.radial_k2     <= '0;
      cfg.tangential_p1 <= '0;
      cfg.tangential_p2 <= '0;
    end else if (wr) begin
      unique case (idx)
        ldr_pkg::REG_FOCAL_X:       cfg.focal_x       <= pwdata[19:0];
        ldr_pkg::REG_FOCAL_Y:       cfg.focal_y       <= pwdata[19:0];
        ldr_pkg::REG_CENTER_X:      cfg.center_x      <= pwdata[19:0];
        ldr_pkg::REG_CENTER_Y:      cfg.center_y      <= pwdata[19:0];
        ldr_pkg::REG_RADIAL_K1:     cfg.radial_k1     <= pwdata[19:0];
        ldr_pkg::REG_RADIAL_K2:     cfg.radial_k2     <= pwdata[19:0];
        ldr_pkg::REG_TANGENTIAL_P1: cfg.tangential_p1 <= pwdata[19:0];
        ldr_pkg::REG_TANGENTIAL_P2: cfg.tangential_p2 <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ldr_pkg::REG_FOCAL_X:       prdata = {12'b0, cfg.focal_x};
      ldr_pkg::REG_FOCAL_Y:       prdata = {12'b0, cfg.focal_y};
      ldr_pkg::REG_CENTER_X:      prdata = {12'b0, cfg.center_x};
      ldr_pkg::REG_CENTER_Y:      prdata = {12'b0, cfg.center_y};
      ldr_pkg::REG_RADIAL_K1:     prdata = 32'(cfg.radial_k1);
      ldr_pkg::REG_RADIAL_K2:     prdata = 32'(cfg.radial_k2);
      ldr_pkg::REG_TANGENTIAL_P1: prdata = 32'(cfg.tangential_p1);
      ldr_pkg::REG_TANGENTIAL_P2: prdata = 32'(cfg.tangential_p2);
      default:                    prdata = '0;
    endcase
  end

endmodule

/* src/ldr_norm.sv */
module ldr_norm (
  input  logic               clk,
  input  logic               en,
  input  logic [11:0]        pix,
  input  logic [19:0]        center,
  input  logic [19:0]        focal,
  output logic signed [19:0] norm
);

  localparam int NS = ldr_pkg::DIV_STG;

  logic [19:0] rem_q [NS+1];
  logic [19:0] low_q [NS+1];
  logic [19:0] quo_q [NS+1];
  logic [19:0] den_q [NS+1];
  logic        neg_q [NS+1];
  logic        ovf_q [NS+1];

  logic signed [20:0] diff;
  logic [20:0]        mag;
  logic [19:0]        den;

  always_comb begin
    diff = $signed({1'b0, pix, 8'b0}) - $signed({1'b0, center});
    mag  = diff[20] ? 21'(-diff) : diff;
    den  = (focal == '0) ? 20'd1 : focal;
  end

  // dividend is |diff| << 16; the top 16 bits seed the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= {4'b0, mag[19:4]};
      low_q[0] <= {mag[3:0], 16'b0};
      quo_q[0] <= '0;
      den_q[0] <= den;
      neg_q[0] <= diff[20];
      ovf_q[0] <= {4'b0, mag[19:4]} >= den;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [19:0] rem_n, low_n, quo_n;

    always_comb begin
      logic [19:0] r, l, q;
      logic [20:0] t;
      r = rem_q[s];
      l = low_q[s];
      q = quo_q[s];
      for (int k = 0; k < ldr_pkg::DIV_PER_STG; k++) begin
        t = {r, l[19]};
        l = {l[18:0], 1'b0};
        if (t >= {1'b0, den_q[s]}) begin
          r = 20'(t - {1'b0, den_q[s]});
          q = {q[18:0], 1'b1};
        end else begin
          r = t[19:0];
          q = {q[18:0], 1'b0};
        end
      end
      rem_n = r;
      low_n = l;
      quo_n = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= rem_n;
        low_q[s+1] <= low_n;
        quo_q[s+1] <= quo_n;
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  // saturate to q4.16
  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg_q[NS]) begin
        norm <= (ovf_q[NS] || quo_q[NS] > 20'd524287) ? 20'sh7FFFF : $signed(quo_q[NS]);
      end else begin
        norm <= (ovf_q[NS] || quo_q[NS] > 20'd524288) ? 20'sh80000 : $signed(20'(-quo_q[NS]));
      end
    end
  end

endmodule

/* src/ldr_poly.sv */
module ldr_poly #(
  parameter int IMAGE_WIDTH  = ldr_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = ldr_pkg::IMAGE_HEIGHT_DEF,
  parameter int RADIAL_K3    = ldr_pkg::RADIAL_K3_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [19:0] x,
  input  logic signed [19:0] y,
  input  ldr_pkg::cfg_t      cfg,
  output ldr_pkg::src_t      res
);

  localparam logic signed [31:0] K3 = 32'(RADIAL_K3);

  logic signed [31:0] k1, k2, p1, p2;
  assign k1 = 32'(cfg.radial_k1);
  assign k2 = 32'(cfg.radial_k2);
  assign p1 = 32'(cfg.tangential_p1);
  assign p2 = 32'(cfg.tangential_p2);

  logic signed [31:0] x1, y1, x2_1, y2_1, xy_1;
  logic signed [31:0] x_2, y_2, xy_2, r2_2, tx_2, ty_2;
  logic signed [31:0] x_3, y_3, r2_3, r4_3, k1r2_3, a_3, b_3, c_3, d_3;
  logic signed [31:0] x_4, y_4, r6_4, k1r2_4, k2r4_4;
  logic signed [33:0] tanx_4, tany_4;
  logic signed [31:0] x_5, y_5, k1r2_5, k2r4_5, k3r6_5;
  logic signed [33:0] tanx_5, tany_5;
  logic signed [31:0] x_6, y_6, radial_6;
  logic signed [33:0] tanx_6, tany_6;
  logic signed [31:0] xr_7, yr_7;
  logic signed [33:0] tanx_7, tany_7;
  logic signed [31:0] xd_8, yd_8;
  logic signed [37:0] pu_9, pv_9;
  logic signed [31:0] r2_c;
  logic signed [63:0] pu_c, pv_c;
  logic signed [37:0] su, sv;
  logic               ok;

  assign r2_c = ldr_pkg::sat32(64'(x2_1) + 64'(y2_1));
  assign pu_c = $signed({44'b0, cfg.focal_x}) * 64'(xd_8);
  assign pv_c = $signed({44'b0, cfg.focal_y}) * 64'(yd_8);
  assign su   = pu_9 + $signed({18'b0, cfg.center_x});
  assign sv   = pv_9 + $signed({18'b0, cfg.center_y});
  assign ok   = !su[37] && !sv[37] && (su[37:8] < 30'(IMAGE_WIDTH))
                && (sv[37:8] < 30'(IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (en) begin
      // squares and cross term
      x1   <= 32'(x);
      y1   <= 32'(y);
      x2_1 <= ldr_pkg::mulq(32'(x), 32'(x));
      y2_1 <= ldr_pkg::mulq(32'(y), 32'(y));
      xy_1 <= ldr_pkg::mulq(32'(x), 32'(y));
      // r^2 and the r^2 + 2x^2 style sums
      x_2  <= x1;
      y_2  <= y1;
      xy_2 <= xy_1;
      r2_2 <= r2_c;
      tx_2 <= ldr_pkg::sat32(64'(r2_c) + (64'(x2_1) <<< 1));
      ty_2 <= ldr_pkg::sat32(64'(r2_c) + (64'(y2_1) <<< 1));
      // r^4, k1 r^2 and tangential products
      x_3    <= x_2;
      y_3    <= y_2;
      r2_3   <= r2_2;
      r4_3   <= ldr_pkg::mulq(r2_2, r2_2);
      k1r2_3 <= ldr_pkg::mulq(k1, r2_2);
      a_3    <= ldr_pkg::mulq(p1, xy_2);
      b_3    <= ldr_pkg::mulq(p2, tx_2);
      c_3    <= ldr_pkg::mulq(p1, ty_2);
      d_3    <= ldr_pkg::mulq(p2, xy_2);
      // r^6, k2 r^4 and the tangential sums
      x_4    <= x_3;
      y_4    <= y_3;
      r6_4   <= ldr_pkg::mulq(r4_3, r2_3);
      k1r2_4 <= k1r2_3;
      k2r4_4 <= ldr_pkg::mulq(k2, r4_3);
      tanx_4 <= (34'(a_3) <<< 1) + 34'(b_3);
      tany_4 <= 34'(c_3) + (34'(d_3) <<< 1);
      // k3 r^6
      x_5    <= x_4;
      y_5    <= y_4;
      k1r2_5 <= k1r2_4;
      k2r4_5 <= k2r4_4;
      k3r6_5 <= ldr_pkg::mulq(K3, r6_4);
      tanx_5 <= tanx_4;
      tany_5 <= tany_4;
      // radial factor
      x_6      <= x_5;
      y_6      <= y_5;
      radial_6 <= ldr_pkg::sat32(64'sd65536 + 64'(k1r2_5) + 64'(k2r4_5) + 64'(k3r6_5));
      tanx_6   <= tanx_5;
      tany_6   <= tany_5;
      // scale by radial
      xr_7   <= ldr_pkg::mulq(x_6, radial_6);
      yr_7   <= ldr_pkg::mulq(y_6, radial_6);
      tanx_7 <= tanx_6;
      tany_7 <= tany_6;
      // distorted normalized position
      xd_8 <= ldr_pkg::sat32(64'(xr_7) + 64'(tanx_7));
      yd_8 <= ldr_pkg::sat32(64'(yr_7) + 64'(tany_7));
      // back to q.8 pixels
      pu_9 <= 38'(pu_c >>> 16);
      pv_9 <= 38'(pv_c >>> 16);
      // bounds check, zero result when outside
      res.src_col   <= ok ? su[19:8] : '0;
      res.src_row   <= ok ? sv[19:8] : '0;
      res.in_bounds <= ok;
    end
  end

endmodule
